// File: src/msd_pkg.sv
// shared types, constants and the symbol table of the morse stream decoder
// no dependencies; used by the decoder top level and the bench
package msd_pkg;

  localparam int MAX_ELEMENTS_DEF = 10;
  localparam int TABLE_LEN_W      = 3;   // longest table entry has 7 elements
  localparam int TABLE_CODE_W     = 7;
  localparam int TABLE_MAX_LEN    = 7;
  localparam int OQ_DEPTH         = 4;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_QUEST   = 8'h3F;

  typedef struct packed {
    logic [7:0] ch;
    logic       unknown;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [7:0] ch;
  } lookup_t;

  // dot = 0, dash = 1, earliest element in the msb of the used bits
  function automatic lookup_t sym_lookup(input logic [TABLE_LEN_W-1:0] len,
                                         input logic [TABLE_CODE_W-1:0] code);
    lookup_t r;
    r.found = 1'b1;
    case ({len, code})
      {3'd2, 7'd1}:  r.ch = "A";
      {3'd4, 7'd8}:  r.ch = "B";
      {3'd4, 7'd10}: r.ch = "C";
      {3'd3, 7'd4}:  r.ch = "D";
      {3'd1, 7'd0}:  r.ch = "E";
      {3'd4, 7'd2}:  r.ch = "F";
      {3'd3, 7'd6}:  r.ch = "G";
      {3'd4, 7'd0}:  r.ch = "H";
      {3'd2, 7'd0}:  r.ch = "I";
      {3'd4, 7'd7}:  r.ch = "J";
      {3'd3, 7'd5}:  r.ch = "K";
      {3'd4, 7'd4}:  r.ch = "L";
      {3'd2, 7'd3}:  r.ch = "M";
      {3'd2, 7'd2}:  r.ch = "N";
      {3'd3, 7'd7}:  r.ch = "O";
      {3'd4, 7'd6}:  r.ch = "P";
      {3'd4, 7'd13}: r.ch = "Q";
      {3'd3, 7'd2}:  r.ch = "R";
      {3'd3, 7'd0}:  r.ch = "S";
      {3'd1, 7'd1}:  r.ch = "T";
      {3'd3, 7'd1}:  r.ch = "U";
      {3'd4, 7'd1}:  r.ch = "V";
      {3'd3, 7'd3}:  r.ch = "W";
      {3'd4, 7'd9}:  r.ch = "X";
      {3'd4, 7'd11}: r.ch = "Y";
      {3'd4, 7'd12}: r.ch = "Z";
      {3'd5, 7'd31}: r.ch = "0";
      {3'd5, 7'd15}: r.ch = "1";
      {3'd5, 7'd7}:  r.ch = "2";
      {3'd5, 7'd3}:  r.ch = "3";
      {3'd5, 7'd1}:  r.ch = "4";
      {3'd5, 7'd0}:  r.ch = "5";
      {3'd5, 7'd16}: r.ch = "6";
      {3'd5, 7'd24}: r.ch = "7";
      {3'd5, 7'd28}: r.ch = "8";
      {3'd5, 7'd30}: r.ch = "9";
      {3'd6, 7'd21}: r.ch = ".";
      {3'd6, 7'd51}: r.ch = ",";
      {3'd6, 7'd12}: r.ch = "?";
      {3'd6, 7'd30}: r.ch = 8'h27;
      {3'd6, 7'd43}: r.ch = "!";
      {3'd5, 7'd18}: r.ch = "/";
      {3'd5, 7'd22}: r.ch = "(";
      {3'd6, 7'd45}: r.ch = ")";
      {3'd5, 7'd8}:  r.ch = "&";
      {3'd6, 7'd56}: r.ch = ":";
      {3'd6, 7'd42}: r.ch = ";";
      {3'd5, 7'd17}: r.ch = "=";
      {3'd5, 7'd10}: r.ch = "+";
      {3'd6, 7'd33}: r.ch = "-";
      {3'd6, 7'd13}: r.ch = "_";
      {3'd6, 7'd18}: r.ch = 8'h22;
      {3'd7, 7'd9}:  r.ch = "$";
      {3'd6, 7'd26}: r.ch = "@";
      default: begin
        r.found = 1'b0;
        r.ch    = CH_QUEST;
      end
    endcase
    return r;
  endfunction

endpackage

// File: src/msd_if.sv
// valid/ready channel interfaces for the morse stream decoder
// input channel carries kind and byte_in, output channel char_out, unknown, last
interface msd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_in;

  modport source (output valid, output kind, output byte_in, input ready);
  modport sink   (input valid, input kind, input byte_in, output ready);
endinterface

interface msd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       unknown;
  logic       last;

  modport source (output valid, output char_out, output unknown, output last, input ready);
  modport sink   (input valid, input char_out, input unknown, input last, output ready);
endinterface

// File: src/msd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read returns the contents before a same-edge write
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/morse_stream_decoder.sv
// morse stream decoder: an accepted item passes the input stage register, then the output queue, to its first result.
// one item per cycle while items give at most one result and the output queue has room; an item with a symbol and a
// separator gives two results, and the single result port then sets the pace.
// the pending symbol lives in a one-entry ram read every cycle, with a bypass of the last write.
// synchronous reset: pending symbol empty (ram entry marked not yet written), queue empty.
module morse_stream_decoder #(
  parameter int MAX_ELEMENTS = msd_pkg::MAX_ELEMENTS_DEF
) (
  input logic         clk,
  input logic         rst,
  msd_in_if.sink      din,
  msd_out_if.source   dout
);
  import msd_pkg::*;

  localparam int LEN_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int STATE_W = MAX_ELEMENTS + LEN_W;
  localparam int OQ_AW   = $clog2(OQ_DEPTH);
  localparam int OQ_CW   = $clog2(OQ_DEPTH + 1);

  // input stage
  logic       s1_valid;
  logic       s1_kind;
  logic [7:0] s1_byte;
  logic       s1_fire;

  // state memory and bypass
  logic               ram_we;
  logic [STATE_W-1:0] ram_wdata;
  logic [STATE_W-1:0] ram_rdata;
  logic               state_vld;
  logic               fwd_we;
  logic [STATE_W-1:0] fwd_data;
  logic [STATE_W-1:0] cur_state;
  logic [MAX_ELEMENTS-1:0] cur_pat;
  logic [LEN_W-1:0]        cur_len;
  logic [MAX_ELEMENTS-1:0] pat_next;
  logic [LEN_W-1:0]        len_next;

  // decode
  logic    is_space, is_sep, is_elem, is_dash, do_flush, emit_sym, emit_sep;
  logic [7:0] sep_ch;
  lookup_t lk;
  logic    sym_short;
  logic [1:0] n_res;
  result_t res0, res1;

  // output queue
  result_t           oq [OQ_DEPTH];
  logic [OQ_AW-1:0]  head, tail;
  logic [OQ_CW-1:0]  count;
  logic [OQ_CW-1:0]  free_slots;
  logic              pop;

  msd_ram #(
    .WIDTH (STATE_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (1'b0),
    .wdata (ram_wdata),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  // a write at the last edge is not yet in the read data
  always_comb begin
    if (fwd_we) begin
      cur_state = fwd_data;
    end else if (state_vld) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = '0;
    end
  end
  assign cur_pat = cur_state[STATE_W-1:LEN_W];
  assign cur_len = cur_state[LEN_W-1:0];

  always_comb begin
    is_space = !s1_kind && (s1_byte == CH_SPACE || s1_byte == CH_TAB);
    is_sep   = !s1_kind && (s1_byte == CH_SLASH || s1_byte == CH_NEWLINE);
    is_dash  = !s1_kind && (s1_byte == CH_DASH);
    is_elem  = is_dash || (!s1_kind && (s1_byte == CH_DOT));
    do_flush = s1_kind || is_space || is_sep;
    emit_sym = do_flush && (cur_len != '0);
    emit_sep = s1_kind || is_sep;
    sep_ch   = (!s1_kind && s1_byte == CH_SLASH) ? CH_SPACE : CH_NEWLINE;
    n_res    = {1'b0, emit_sym} + {1'b0, emit_sep};

    sym_short = (cur_len <= LEN_W'(TABLE_MAX_LEN));
    lk = sym_lookup(cur_len[TABLE_LEN_W-1:0], cur_pat[TABLE_CODE_W-1:0]);
    if (!sym_short) begin
      lk.found = 1'b0;
      lk.ch    = CH_QUEST;
    end

    res1.ch      = sep_ch;
    res1.unknown = 1'b0;
    res1.last    = 1'b1;
    if (emit_sym) begin
      res0.ch      = lk.ch;
      res0.unknown = !lk.found;
      res0.last    = !emit_sep;
    end else begin
      res0 = res1;
    end

    pat_next = cur_pat;
    len_next = cur_len;
    if (do_flush) begin
      pat_next = '0;
      len_next = '0;
    end else if (is_elem) begin
      if (cur_len < LEN_W'(MAX_ELEMENTS)) begin
        pat_next = {cur_pat[MAX_ELEMENTS-2:0], is_dash};
        len_next = cur_len + LEN_W'(1);
      end else begin
        // overflow drops the symbol and this element
        pat_next = '0;
        len_next = '0;
      end
    end
  end

  assign free_slots = OQ_CW'(OQ_DEPTH) - count;
  assign s1_fire    = s1_valid && (OQ_CW'(n_res) <= free_slots);
  assign din.ready  = !s1_valid || s1_fire;
  assign ram_we     = s1_fire;
  assign ram_wdata  = {pat_next, len_next};

  assign pop          = dout.valid && dout.ready;
  assign dout.valid   = (count != '0);
  assign dout.char_out = oq[head].ch;
  assign dout.unknown  = oq[head].unknown;
  assign dout.last     = oq[head].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      state_vld <= 1'b0;
      fwd_we    <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
    end else begin
      if (din.ready) begin
        s1_valid <= din.valid;
      end
      fwd_we <= ram_we;
      if (ram_we) begin
        state_vld <= 1'b1;
      end
      if (pop) begin
        head <= head + OQ_AW'(1);
      end
      if (s1_fire) begin
        tail <= tail + OQ_AW'(n_res);
      end
      count <= count + (s1_fire ? OQ_CW'(n_res) : '0) - OQ_CW'(pop);
    end
    if (din.ready && din.valid) begin
      s1_kind <= din.kind;
      s1_byte <= din.byte_in;
    end
    fwd_data <= ram_wdata;
    if (s1_fire && n_res != 2'd0) begin
      oq[tail] <= res0;
    end
    if (s1_fire && n_res == 2'd2) begin
      oq[tail + OQ_AW'(1)] <= res1;
    end
  end

  // queue never overfills and never underflows
  assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CW'(OQ_DEPTH))
    else $error("output queue count out of range");

  // pending symbol length stays within the element limit
  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> cur_len <= LEN_W'(MAX_ELEMENTS))
    else $error("pending symbol length beyond limit");

  // a stalled item keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte) && $stable(s1_kind))
    else $error("stalled item changed");

  // an item giving no result into an empty queue leaves no result visible
  assert property (@(posedge clk) disable iff (rst)
    s1_fire && n_res == 2'd0 && count == '0 |=> !dout.valid)
    else $error("result appeared from an item with no result");

endmodule

// File: bench/tb_top.sv
// self-checking bench for morse_stream_decoder: directed and random text streams
// a scoreboard class predicts every character item; depends on msd_pkg, msd_if, the rtl
module tb_top;
  import msd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 2000;
  localparam int HOLD_AFTER  = 700;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic       kind;
    logic [7:0] b;
  } stim_t;

  class morse_scoreboard;
    string      sym_codes[54];
    logic [7:0] sym_chars[54];
    logic [MAX_ELEMENTS_DEF-1:0] elems;
    int unsigned n_elems;
    result_t    expected_q[$];
    int         errors;

    function new();
      sym_codes = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
                    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
                    "..-", "...-", ".--", "-..-", "-.--", "--..",
                    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
                    "---..", "----.",
                    ".-.-.-", "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.",
                    "-.--.-", ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-",
                    "..--.-", ".-..-.", "...-..-", ".--.-."};
      sym_chars = '{"A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M",
                    "N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
                    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                    ".", ",", "?", 8'h27, "!", "/", "(", ")", "&", ":", ";", "=", "+",
                    "-", "_", 8'h22, "$", "@"};
      elems   = '0;
      n_elems = 0;
      errors  = 0;
    endfunction

    // decode the pending symbol into one character item and clear it
    function bit decode_pending(output result_t r);
      int unsigned len;
      logic [MAX_ELEMENTS_DEF-1:0] bits;
      r = '{ch: CH_QUEST, unknown: 1'b1, last: 1'b0};
      if (n_elems == 0) return 1'b0;
      for (int i = 0; i < 54; i++) begin
        len  = sym_codes[i].len();
        bits = '0;
        for (int k = 0; k < sym_codes[i].len(); k++)
          bits = {bits[MAX_ELEMENTS_DEF-2:0], sym_codes[i].getc(k) == CH_DASH};
        if (len == n_elems && bits == elems) begin
          r.ch      = sym_chars[i];
          r.unknown = 1'b0;
        end
      end
      elems   = '0;
      n_elems = 0;
      return 1'b1;
    endfunction

    function void note_item(input logic kind, input logic [7:0] b);
      result_t res[2];
      result_t r;
      int n;
      n = 0;
      if (kind) begin
        if (decode_pending(r)) begin res[n] = r; n++; end
        res[n] = '{ch: CH_NEWLINE, unknown: 1'b0, last: 1'b0}; n++;
      end else begin
        case (b)
          CH_SPACE, CH_TAB: begin
            if (decode_pending(r)) begin res[n] = r; n++; end
          end
          CH_SLASH, CH_NEWLINE: begin
            if (decode_pending(r)) begin res[n] = r; n++; end
            res[n] = '{ch: (b == CH_SLASH) ? CH_SPACE : CH_NEWLINE, unknown: 1'b0,
                       last: 1'b0};
            n++;
          end
          CH_DOT, CH_DASH: begin
            // element on a full symbol drops both
            if (n_elems < MAX_ELEMENTS_DEF) begin
              elems = {elems[MAX_ELEMENTS_DEF-2:0], b == CH_DASH};
              n_elems++;
            end else begin
              elems   = '0;
              n_elems = 0;
            end
          end
          default: ;
        endcase
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
    endfunction

    function void check_char(input result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item ch %h unknown %b last %b", $time, got.ch,
                 got.unknown, got.last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.ch !== exp_r.ch) begin
        $display("%0t: char_out expected %h got %h", $time, exp_r.ch, got.ch);
        errors++;
      end
      if (got.unknown !== exp_r.unknown) begin
        $display("%0t: unknown expected %b got %b", $time, exp_r.unknown, got.unknown);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $display("%0t: last expected %b got %b", $time, exp_r.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  msd_in_if  in_ch();
  msd_out_if out_ch();

  morse_stream_decoder u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  morse_scoreboard sb = new();
  stim_t stim_q[$];
  int    decoded_cnt  = 0;   // items that the block does not ignore
  int    accepted_cnt = 0;
  int    cycles       = 0;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.kind    = 1'b0;
    in_ch.byte_in = 8'h00;
    out_ch.ready  = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_char('{ch: out_ch.char_out, unknown: out_ch.unknown, last: out_ch.last});
  end

  function automatic void add_item(input logic kind, input logic [7:0] b);
    stim_q.push_back('{kind: kind, b: b});
    if (kind || b inside {CH_SPACE, CH_TAB, CH_SLASH, CH_NEWLINE, CH_DOT, CH_DASH})
      decoded_cnt++;
  endfunction

  function automatic void add_code(input string s);
    for (int k = 0; k < s.len(); k++) add_item(1'b0, s.getc(k));
  endfunction

  function automatic void add_separator();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7)       add_item(1'b0, CH_SPACE);
    else if (r < 10) add_item(1'b0, CH_TAB);
    else if (r < 14) add_item(1'b0, CH_SLASH);
    else if (r < 18) add_item(1'b0, CH_NEWLINE);
    else             add_item(1'b1, 8'($urandom_range(0, 255)));
  endfunction

  task automatic drive_item(input stim_t it);
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.kind    = it.kind;
    in_ch.byte_in = it.b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it.kind, it.b);
    accepted_cnt++;
  endtask

  task automatic send_all();
    int burst;
    int gap;
    while (stim_q.size() > 0) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      for (int i = 0; i < burst && stim_q.size() > 0; i++) drive_item(stim_q.pop_front());
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // receiver: stall patterns that change after spans of random length, plus one long hold-off
  initial begin : rx_stall
    int mode;
    int span;
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (int tick = 0; tick < span; tick++) begin
        @(negedge clk);
        if (!held && accepted_cnt >= HOLD_AFTER) begin
          held      = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready = 1'b0;
        end else begin
          case (mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = 1'($urandom_range(0, 1));
            2: out_ch.ready = (tick % 4 == 0);
            default: out_ch.ready = ($urandom_range(0, 9) != 0);
          endcase
        end
      end
    end
  end

  initial begin : main
    int pick;
    int len;

    // directed: byte extremes, empty separators, real question mark, overflow, end of stream
    add_item(1'b0, 8'h00);
    add_item(1'b0, 8'hFF);
    add_item(1'b0, CH_SPACE);
    add_item(1'b0, CH_SLASH);
    add_item(1'b0, CH_NEWLINE);
    add_item(1'b0, CH_TAB);
    add_code("..--..");
    add_item(1'b0, CH_TAB);
    add_code("----------");
    add_item(1'b0, CH_DOT);
    add_item(1'b0, CH_SLASH);
    add_item(1'b1, 8'hFF);
    add_code(".-");
    add_item(1'b1, 8'h00);

    while (decoded_cnt < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        add_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        add_code(sb.sym_codes[$urandom_range(0, 53)]);
        add_separator();
      end else if (pick < 90) begin
        // random symbols reach unknown codes and the overflow path
        len = $urandom_range(1, 12);
        repeat (len) add_item(1'b0, $urandom_range(0, 1) ? CH_DASH : CH_DOT);
        add_separator();
      end else begin
        add_separator();
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_all();
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
